FILE: design/cau_pkg.sv
// shared definitions for the complex arithmetic unit
// operation codes and default widths, no dependencies
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_MAG = 3'd4;

endpackage

FILE: design/complex_arithmetic_unit_top.sv
// complex arithmetic unit top level: add, sub, mul, div and magnitude on fixed point
// path from accept to result: input capture, products, the bit-per-stage divider chain
// and the output register; the sqrt runs in the first DATA_WIDTH chain stages
// throughput: one item per cycle, the whole pipe holds while the result is not taken
// reset: rst_n asynchronous active low clears all valid bits, payload is not reset
// depends on cau_pkg
module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // func[2:0], a_re, a_im, b_re, b_im, zero pad
    input  logic [((3 + 4 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // res_re, res_im, status, overflow, zero pad
    output logic [((2 * DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int OW = ((2 * W + 2 + 7) / 8) * 8;
    localparam int NW = 2 * W + F;
    localparam int NS = NW;
    localparam int SW = NW + 1;
    localparam int PW = 2 * W;

    localparam logic signed [SW-1:0] SMAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    // returns {overflow, value}
    function automatic logic [W:0] sat_f(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > SMAX)
        begin
            r = {1'b1, SMAX[W-1:0]};
        end
        else if (v < SMIN)
        begin
            r = {1'b1, SMIN[W-1:0]};
        end
        else
        begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: input capture
    logic                s1_vld_reg;
    logic [2:0]          s1_func_reg;
    logic signed [W-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // stage 2: products and sums
    logic                 s2_vld_reg;
    logic [2:0]           s2_func_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] p_aar_reg, p_aai_reg, p_bbr_reg, p_bbi_reg;
    logic signed [W:0]    add_re_reg, add_im_reg, sub_re_reg, sub_im_reg;

    // chain stages
    logic          c_vld_reg  [0:NS];
    logic [2:0]    c_func_reg [0:NS];
    logic [W-1:0]  c_er_reg   [0:NS];
    logic [W-1:0]  c_ei_reg   [0:NS];
    logic          c_eo_reg   [0:NS];
    logic          c_zero_reg [0:NS];
    logic          c_sre_reg  [0:NS];
    logic          c_sim_reg  [0:NS];
    logic [PW-1:0] c_den_reg  [0:NS];
    logic [PW-1:0] c_rre_reg  [0:NS];
    logic [NW-1:0] c_qre_reg  [0:NS];
    logic [NW-1:0] c_nre_reg  [0:NS];
    logic [PW-1:0] c_rim_reg  [0:NS];
    logic [NW-1:0] c_qim_reg  [0:NS];
    logic [NW-1:0] c_nim_reg  [0:NS];
    logic [W:0]    c_srem_reg [0:NS];
    logic [W-1:0]  c_root_reg [0:NS];
    logic [PW-1:0] c_x_reg    [0:NS];

    logic          c_vld_next  [0:NS];
    logic [2:0]    c_func_next [0:NS];
    logic [W-1:0]  c_er_next   [0:NS];
    logic [W-1:0]  c_ei_next   [0:NS];
    logic          c_eo_next   [0:NS];
    logic          c_zero_next [0:NS];
    logic          c_sre_next  [0:NS];
    logic          c_sim_next  [0:NS];
    logic [PW-1:0] c_den_next  [0:NS];
    logic [PW-1:0] c_rre_next  [0:NS];
    logic [NW-1:0] c_qre_next  [0:NS];
    logic [NW-1:0] c_nre_next  [0:NS];
    logic [PW-1:0] c_rim_next  [0:NS];
    logic [NW-1:0] c_qim_next  [0:NS];
    logic [NW-1:0] c_nim_next  [0:NS];
    logic [W:0]    c_srem_next [0:NS];
    logic [W-1:0]  c_root_next [0:NS];
    logic [PW-1:0] c_x_next    [0:NS];

    logic          out_vld_reg;
    logic [W-1:0]  out_re_reg, out_im_reg;
    logic          out_st_reg, out_ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= c_vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= s_tdata[2:0];
            s1_ar_reg   <= s_tdata[3 +: W];
            s1_ai_reg   <= s_tdata[3 + W +: W];
            s1_br_reg   <= s_tdata[3 + 2 * W +: W];
            s1_bi_reg   <= s_tdata[3 + 3 * W +: W];

            s2_func_reg <= s1_func_reg;
            p_rr_reg    <= s1_ar_reg * s1_br_reg;
            p_ii_reg    <= s1_ai_reg * s1_bi_reg;
            p_ri_reg    <= s1_ar_reg * s1_bi_reg;
            p_ir_reg    <= s1_ai_reg * s1_br_reg;
            p_aar_reg   <= s1_ar_reg * s1_ar_reg;
            p_aai_reg   <= s1_ai_reg * s1_ai_reg;
            p_bbr_reg   <= s1_br_reg * s1_br_reg;
            p_bbi_reg   <= s1_bi_reg * s1_bi_reg;
            add_re_reg  <= (W+1)'(s1_ar_reg) + (W+1)'(s1_br_reg);
            add_im_reg  <= (W+1)'(s1_ai_reg) + (W+1)'(s1_bi_reg);
            sub_re_reg  <= (W+1)'(s1_ar_reg) - (W+1)'(s1_br_reg);
            sub_im_reg  <= (W+1)'(s1_ai_reg) - (W+1)'(s1_bi_reg);
        end
    end

    // stage 3: combine products, load the divider and sqrt lanes
    logic signed [PW:0]  mre, mim, dre, dim;
    logic [PW:0]         dre_mag, dim_mag;
    logic [W:0]          sat_re, sat_im;

    always_comb
    begin
        logic [PW:0]  t_re, t_im;
        logic [W+2:0] tr;
        logic [W+2:0] trial;

        mre     = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
        mim     = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
        dre     = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
        dim     = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
        dre_mag = dre[PW] ? -dre : dre;
        dim_mag = dim[PW] ? -dim : dim;

        unique case (s2_func_reg)
            FUNC_ADD:
            begin
                sat_re = sat_f(SW'(add_re_reg));
                sat_im = sat_f(SW'(add_im_reg));
            end
            FUNC_SUB:
            begin
                sat_re = sat_f(SW'(sub_re_reg));
                sat_im = sat_f(SW'(sub_im_reg));
            end
            FUNC_MUL:
            begin
                sat_re = sat_f(SW'(mre >>> F));
                sat_im = sat_f(SW'(mim >>> F));
            end
            default:
            begin
                sat_re = '0;
                sat_im = '0;
            end
        endcase

        c_vld_next[0]  = s2_vld_reg;
        c_func_next[0] = s2_func_reg;
        c_er_next[0]   = sat_re[W-1:0];
        c_ei_next[0]   = sat_im[W-1:0];
        c_eo_next[0]   = sat_re[W] | sat_im[W];
        c_den_next[0]  = PW'(p_bbr_reg) + PW'(p_bbi_reg);
        c_zero_next[0] = (c_den_next[0] == '0);
        c_sre_next[0]  = dre[PW];
        c_sim_next[0]  = dim[PW];
        c_rre_next[0]  = '0;
        c_qre_next[0]  = '0;
        c_nre_next[0]  = NW'(dre_mag[PW-1:0]) << F;
        c_rim_next[0]  = '0;
        c_qim_next[0]  = '0;
        c_nim_next[0]  = NW'(dim_mag[PW-1:0]) << F;
        c_srem_next[0] = '0;
        c_root_next[0] = '0;
        c_x_next[0]    = PW'(p_aar_reg) + PW'(p_aai_reg);

        // one quotient bit per stage for both lanes, one root bit per stage for the first W
        for (int k = 1; k <= NS; k++)
        begin
            c_vld_next[k]  = c_vld_reg[k-1];
            c_func_next[k] = c_func_reg[k-1];
            c_er_next[k]   = c_er_reg[k-1];
            c_ei_next[k]   = c_ei_reg[k-1];
            c_eo_next[k]   = c_eo_reg[k-1];
            c_zero_next[k] = c_zero_reg[k-1];
            c_sre_next[k]  = c_sre_reg[k-1];
            c_sim_next[k]  = c_sim_reg[k-1];
            c_den_next[k]  = c_den_reg[k-1];

            t_re = {c_rre_reg[k-1], c_nre_reg[k-1][NW-1]};
            if (t_re >= {1'b0, c_den_reg[k-1]})
            begin
                t_re          = t_re - {1'b0, c_den_reg[k-1]};
                c_qre_next[k] = {c_qre_reg[k-1][NW-2:0], 1'b1};
            end
            else
            begin
                c_qre_next[k] = {c_qre_reg[k-1][NW-2:0], 1'b0};
            end
            c_rre_next[k] = t_re[PW-1:0];
            c_nre_next[k] = c_nre_reg[k-1] << 1;

            t_im = {c_rim_reg[k-1], c_nim_reg[k-1][NW-1]};
            if (t_im >= {1'b0, c_den_reg[k-1]})
            begin
                t_im          = t_im - {1'b0, c_den_reg[k-1]};
                c_qim_next[k] = {c_qim_reg[k-1][NW-2:0], 1'b1};
            end
            else
            begin
                c_qim_next[k] = {c_qim_reg[k-1][NW-2:0], 1'b0};
            end
            c_rim_next[k] = t_im[PW-1:0];
            c_nim_next[k] = c_nim_reg[k-1] << 1;

            tr    = {c_srem_reg[k-1], c_x_reg[k-1][PW-1:PW-2]};
            trial = {1'b0, c_root_reg[k-1], 2'b01};
            if (k > W)
            begin
                c_srem_next[k] = c_srem_reg[k-1];
                c_root_next[k] = c_root_reg[k-1];
            end
            else if (tr >= trial)
            begin
                tr             = tr - trial;
                c_srem_next[k] = tr[W:0];
                c_root_next[k] = {c_root_reg[k-1][W-2:0], 1'b1};
            end
            else
            begin
                c_srem_next[k] = tr[W:0];
                c_root_next[k] = {c_root_reg[k-1][W-2:0], 1'b0};
            end
            c_x_next[k] = c_x_reg[k-1] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                c_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                c_vld_reg[k] <= c_vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                c_func_reg[k] <= c_func_next[k];
                c_er_reg[k]   <= c_er_next[k];
                c_ei_reg[k]   <= c_ei_next[k];
                c_eo_reg[k]   <= c_eo_next[k];
                c_zero_reg[k] <= c_zero_next[k];
                c_sre_reg[k]  <= c_sre_next[k];
                c_sim_reg[k]  <= c_sim_next[k];
                c_den_reg[k]  <= c_den_next[k];
                c_rre_reg[k]  <= c_rre_next[k];
                c_qre_reg[k]  <= c_qre_next[k];
                c_nre_reg[k]  <= c_nre_next[k];
                c_rim_reg[k]  <= c_rim_next[k];
                c_qim_reg[k]  <= c_qim_next[k];
                c_nim_reg[k]  <= c_nim_next[k];
                c_srem_reg[k] <= c_srem_next[k];
                c_root_reg[k] <= c_root_next[k];
                c_x_reg[k]    <= c_x_next[k];
            end
        end
    end

    // final select and saturation of quotient and root
    logic [SW-1:0] q_re_s, q_im_s;
    logic [W:0]    f_re, f_im, f_mag;
    logic [W-1:0]  out_re_next, out_im_next;
    logic          out_st_next, out_ov_next;

    always_comb
    begin
        q_re_s = c_sre_reg[NS] ? -{1'b0, c_qre_reg[NS]} : {1'b0, c_qre_reg[NS]};
        q_im_s = c_sim_reg[NS] ? -{1'b0, c_qim_reg[NS]} : {1'b0, c_qim_reg[NS]};
        f_re   = sat_f(q_re_s);
        f_im   = sat_f(q_im_s);
        f_mag  = sat_f(SW'({1'b0, c_root_reg[NS]}));

        unique case (c_func_reg[NS])
            FUNC_ADD, FUNC_SUB, FUNC_MUL:
            begin
                out_re_next = c_er_reg[NS];
                out_im_next = c_ei_reg[NS];
                out_st_next = 1'b0;
                out_ov_next = c_eo_reg[NS];
            end
            FUNC_DIV:
            begin
                if (c_zero_reg[NS])
                begin
                    out_re_next = '0;
                    out_im_next = '0;
                    out_st_next = 1'b1;
                    out_ov_next = 1'b0;
                end
                else
                begin
                    out_re_next = f_re[W-1:0];
                    out_im_next = f_im[W-1:0];
                    out_st_next = 1'b0;
                    out_ov_next = f_re[W] | f_im[W];
                end
            end
            FUNC_MAG:
            begin
                out_re_next = f_mag[W-1:0];
                out_im_next = '0;
                out_st_next = 1'b0;
                out_ov_next = f_mag[W];
            end
            default:
            begin
                out_re_next = '0;
                out_im_next = '0;
                out_st_next = 1'b0;
                out_ov_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            out_st_reg <= out_st_next;
            out_ov_reg <= out_ov_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OW'({out_ov_reg, out_st_reg, out_im_reg, out_re_reg});

endmodule

FILE: bench/cau_checker.sv
// checker for the complex arithmetic unit: watches both stream channels,
// predicts each result from the accepted operands and compares; depends on cau_pkg
`timescale 1ns / 1ps
module cau_checker
    import cau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        status;
        logic        overflow;
    } cplx_result_t;

    cplx_result_t result_q[$];

    assign pending = result_q.size();

    localparam logic signed [127:0] SAT_MAX = 128'sd2147483647;
    localparam logic signed [127:0] SAT_MIN = -128'sd2147483648;

    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        if (v > SAT_MAX)
        begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < SAT_MIN)
        begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // truncating signed division of (num << 16) by a positive divisor
    function automatic logic signed [127:0] frac_div(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num < 0 ? -num : num;
        q = (mag << 16) / den;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic cplx_result_t compute_result(input logic [135:0] d);
        cplx_result_t r;
        logic [2:0] op;
        logic signed [127:0] ar, ai, br, bi, den, t1, t2;
        logic ovf;
        op = d[2:0];
        ar = $signed(d[34:3]);
        ai = $signed(d[66:35]);
        br = $signed(d[98:67]);
        bi = $signed(d[130:99]);
        ovf = 1'b0;
        r = '0;
        case (op)
            FUNC_ADD:
            begin
                r.re = clamp32(ar + br, ovf);
                r.im = clamp32(ai + bi, ovf);
            end
            FUNC_SUB:
            begin
                r.re = clamp32(ar - br, ovf);
                r.im = clamp32(ai - bi, ovf);
            end
            FUNC_MUL:
            begin
                t1 = ar * br - ai * bi;
                t2 = ar * bi + ai * br;
                r.re = clamp32(t1 >>> 16, ovf);
                r.im = clamp32(t2 >>> 16, ovf);
            end
            FUNC_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.status = 1'b1;
                else
                begin
                    r.re = clamp32(frac_div(ar * br + ai * bi, den), ovf);
                    r.im = clamp32(frac_div(ai * br - ar * bi, den), ovf);
                end
            end
            FUNC_MAG:
                r.re = clamp32($signed({64'd0, isqrt(ar * ar + ai * ai)}), ovf);
            default:
                ;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cplx_result_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            result_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("unexpected result item %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata[31:0] != want.re)
                        report_mismatch("res_re", m_tdata[31:0], want.re);
                    if (m_tdata[63:32] != want.im)
                        report_mismatch("res_im", m_tdata[63:32], want.im);
                    if (m_tdata[64] != want.status)
                        report_mismatch("status", 32'(m_tdata[64]), 32'(want.status));
                    if (m_tdata[65] != want.overflow)
                        report_mismatch("overflow", 32'(m_tdata[65]), 32'(want.overflow));
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(compute_result(s_tdata));
        end
    end

endmodule

FILE: bench/tb_top.sv
// testbench top for the complex arithmetic unit: clock, reset, operand stimulus
// and verdict; depends on cau_pkg, complex_arithmetic_unit_top and cau_checker
`timescale 1ns / 1ps
module tb_top;
    import cau_pkg::*;

    localparam int LATENCY = 83;
    localparam int IDLE_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    int           fail_count;
    int           pending;
    logic         sink_hold = 1'b0;
    int           idle_cycles = 0;

    always #4 clk = ~clk;

    complex_arithmetic_unit_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cau_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // operand value leaning toward edges and small magnitudes
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        int gap;
        s_tdata <= {5'd0, bi, br, ai, ar, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random();
        logic [2:0] op;
        op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        if (op == FUNC_DIV && $urandom_range(0, 15) == 0)
            send_item(op, pick_operand(), pick_operand(), 32'd0, 32'd0);
        else
            send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    endtask

    // result side: random stalls, plus a long forced hold while sink_hold is set
    always @(negedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 3)
            m_tready <= 1'b0;
        else if ($urandom_range(0, 99) < 25)
            m_tready <= ~m_tready;
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        sink_hold = 1'b0;
        wait (rst_n);
        repeat (600) @(negedge clk);
        sink_hold = 1'b1;
        repeat (400) @(negedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: every operation, field extremes, zero divisor, unused codes
        send_item(FUNC_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
        send_item(FUNC_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000);
        send_item(FUNC_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
        send_item(FUNC_SUB, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(FUNC_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(FUNC_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_item(FUNC_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
        send_item(FUNC_MUL, 32'h00018000, 32'hfffe0000, 32'h00020000, 32'h00008000);
        send_item(FUNC_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
        send_item(FUNC_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000);
        send_item(FUNC_DIV, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_item(FUNC_DIV, 32'hffffffff, 32'h00000001, 32'h00030000, 32'hfffd0000);
        send_item(FUNC_MAG, 32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0);
        send_item(FUNC_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
        send_item(FUNC_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_item(3'd7, 32'h80000000, 32'h7fffffff, 32'h0, 32'h1);
        for (int i = 0; i < 1530; i++)
        begin
            if (i == 700)
            begin
                // pause until the pipe has drained
                s_tvalid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_random();
        end
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
